/* src/mse_pkg.sv */
package mse_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned NumStacksDef = 4;
  localparam int unsigned MaxDepthDef  = 16;

  // Fixed field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned IdxW    = 2;
  localparam int unsigned WordW   = 64;
  localparam int unsigned StatusW = 2;

  // Limit registers
  localparam int unsigned LimitW       = 5;
  localparam int unsigned NumLimitRegs = 4;
  localparam logic [LimitW-1:0] LimitReset = 5'd16;

  // APB port
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgAddrW  = 4;
  localparam int unsigned RegSelLsb = 2;

  typedef logic [LimitW-1:0] limit_t;

  typedef enum logic [OpW-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE    = 2'd0,
    ST_DROPPED = 2'd1,
    ST_EMPTY   = 2'd2
  } status_e;

  // Source of the popped word on the result
  typedef enum logic [1:0] {
    VAL_ZERO = 2'd0,
    VAL_ONES = 2'd1,
    VAL_RAM  = 2'd2
  } val_sel_e;

  typedef struct packed {
    status_e  status;
    val_sel_e sel;
  } result_t;

endpackage

/* src/mse_cfg_regs.sv */
module mse_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mse_pkg::CfgAddrW-1:0]      paddr,
  input  logic [mse_pkg::CfgDataW-1:0]      pwdata,
  output logic [mse_pkg::CfgDataW-1:0]      prdata,
  output logic                              pready,
  output mse_pkg::limit_t [mse_pkg::NumLimitRegs-1:0] limits_o
);

  mse_pkg::limit_t [mse_pkg::NumLimitRegs-1:0] limit_q;
  logic [mse_pkg::CfgAddrW-mse_pkg::RegSelLsb-1:0] reg_sel;

  assign reg_sel = paddr[mse_pkg::CfgAddrW-1:mse_pkg::RegSelLsb];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mse_pkg::NumLimitRegs; i++) begin
        limit_q[i] <= mse_pkg::LimitReset;
      end
    end else if (psel && penable && pwrite) begin
      limit_q[reg_sel] <= pwdata[mse_pkg::LimitW-1:0];
    end
  end

  assign prdata   = {{(mse_pkg::CfgDataW-mse_pkg::LimitW){1'b0}}, limit_q[reg_sel]};
  assign pready   = 1'b1;
  assign limits_o = limit_q;

endmodule

/* src/mse_ctrl.sv */
module mse_ctrl #(
  parameter int unsigned NumStacks = mse_pkg::NumStacksDef,
  parameter int unsigned MaxDepth  = mse_pkg::MaxDepthDef,
  parameter int unsigned CntW      = 5,
  parameter int unsigned AddrW     = 6
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        accept_i,
  input  logic [mse_pkg::OpW-1:0]                     operation_i,
  input  logic [mse_pkg::IdxW-1:0]                    stack_index_i,
  input  mse_pkg::limit_t [mse_pkg::NumLimitRegs-1:0] limits_i,
  output logic                                        mem_we_o,
  output logic                                        mem_re_o,
  output logic [AddrW-1:0]                            mem_addr_o,
  output mse_pkg::result_t                            result_o
);

  localparam int unsigned SelW = (NumStacks > 1) ? $clog2(NumStacks) : 1;
  localparam int unsigned PosW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;
  localparam int unsigned CmpW = (CntW > mse_pkg::LimitW) ? CntW : mse_pkg::LimitW;

  logic [CntW-1:0] fill_q [NumStacks];
  logic [CntW-1:0] fill_d [NumStacks];
  logic [SelW-1:0] sel;
  logic            present;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] cnt_dec;
  logic [CmpW-1:0] cnt_x;
  logic [CmpW-1:0] lim_x;
  logic            full;
  logic [PosW-1:0] pos;

  assign sel     = stack_index_i[SelW-1:0];
  assign present = 32'(stack_index_i) < NumStacks;
  assign cnt     = present ? fill_q[sel] : '0;
  assign cnt_dec = cnt - CntW'(1);
  assign cnt_x   = CmpW'(cnt);
  assign lim_x   = CmpW'(limits_i[stack_index_i]);
  // limit above depth acts as depth; count at or above limit is full
  assign full    = (lim_x == '0) || (cnt_x >= lim_x) || (cnt_x >= CmpW'(MaxDepth));

  always_comb begin
    fill_d   = fill_q;
    mem_we_o = 1'b0;
    mem_re_o = 1'b0;
    pos      = '0;
    result_o = '{status: mse_pkg::ST_DONE, sel: mse_pkg::VAL_ZERO};
    unique case (mse_pkg::op_e'(operation_i))
      mse_pkg::OP_PUSH: begin
        if (!present || full) begin
          result_o.status = mse_pkg::ST_DROPPED;
        end else begin
          mem_we_o    = accept_i;
          pos         = cnt[PosW-1:0];
          fill_d[sel] = cnt + CntW'(1);
        end
      end
      mse_pkg::OP_POP: begin
        if (!present || cnt == '0) begin
          result_o.status = mse_pkg::ST_EMPTY;
          result_o.sel    = mse_pkg::VAL_ONES;
        end else begin
          mem_re_o     = accept_i;
          pos          = cnt_dec[PosW-1:0];
          result_o.sel = mse_pkg::VAL_RAM;
          fill_d[sel]  = cnt_dec;
        end
      end
      mse_pkg::OP_CLEAR: begin
        if (present) begin
          fill_d[sel] = '0;
        end
      end
      default: ;
    endcase
  end

  // stack s owns entries s*MaxDepth .. s*MaxDepth+MaxDepth-1
  assign mem_addr_o = AddrW'(32'(sel) * MaxDepth) + AddrW'(pos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumStacks; i++) begin
        fill_q[i] <= '0;
      end
    end else if (accept_i) begin
      fill_q <= fill_d;
    end
  end

endmodule

/* src/mse_entry_ram.sv */
module mse_entry_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6,
  parameter int unsigned DataW = 64
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // single port, read data registered and held until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/multi_stack_engine_unit.sv */
// Channel | Direction | Handshake              | Word
// --------+-----------+------------------------+----------------------------------------
// in      | input     | in_valid_i/in_ready_o  | operation_i, stack_index_i, push_value_i
// out     | output    | out_valid_o/out_ready_i| pop_value_o, status_o
// cfg     | input     | APB psel/penable/pready| limit_stack0..3 at byte offsets 0,4,8,12
//
// Per word, at the accept edge, counts are read and updated, the entry RAM
// is written (push) or read (pop), and the result is loaded into the output
// register. One word per cycle while out_ready_i holds.
// A stalled result blocks new input words; the RAM read data stays put then.
// Reset clears fill counts and sets limits to 16; the RAM is not cleared,
// since a pop only ever reads entries below the fill count.
module multi_stack_engine_unit #(
  parameter int unsigned NumStacks = mse_pkg::NumStacksDef,
  parameter int unsigned MaxDepth  = mse_pkg::MaxDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input words
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [mse_pkg::OpW-1:0]          operation_i,
  input  logic [mse_pkg::IdxW-1:0]         stack_index_i,
  input  logic signed [mse_pkg::WordW-1:0] push_value_i,
  // result words
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [mse_pkg::WordW-1:0] pop_value_o,
  output logic [mse_pkg::StatusW-1:0]      status_o,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mse_pkg::CfgAddrW-1:0]     paddr,
  input  logic [mse_pkg::CfgDataW-1:0]     pwdata,
  output logic [mse_pkg::CfgDataW-1:0]     prdata,
  output logic                             pready
);

  localparam int unsigned Entries = NumStacks * MaxDepth;
  localparam int unsigned AddrW   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW    = $clog2(MaxDepth + 1);

  mse_pkg::limit_t [mse_pkg::NumLimitRegs-1:0] limits;
  mse_pkg::result_t                            result;
  mse_pkg::result_t                            res_q;
  logic                                        out_valid_q;
  logic                                        in_fire;
  logic                                        mem_we;
  logic                                        mem_re;
  logic [AddrW-1:0]                            mem_addr;
  logic [mse_pkg::WordW-1:0]                   rdata;

  // output register frees up in the same cycle it is taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  mse_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .limits_o (limits)
  );

  mse_ctrl #(
    .NumStacks (NumStacks),
    .MaxDepth  (MaxDepth),
    .CntW      (CntW),
    .AddrW     (AddrW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_fire),
    .operation_i   (operation_i),
    .stack_index_i (stack_index_i),
    .limits_i      (limits),
    .mem_we_o      (mem_we),
    .mem_re_o      (mem_re),
    .mem_addr_o    (mem_addr),
    .result_o      (result)
  );

  // a pushed entry is written into the RAM before any later pop can read it: no forwarding needed
  mse_entry_ram #(
    .Depth (Entries),
    .AddrW (AddrW),
    .DataW (mse_pkg::WordW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (push_value_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= result;
    end
  end

  always_comb begin
    unique case (res_q.sel)
      mse_pkg::VAL_RAM:  pop_value_o = rdata;
      mse_pkg::VAL_ONES: pop_value_o = '1;
      default:           pop_value_o = '0;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = res_q.status;

  // RAM port is single: never read and write together
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mem_we && mem_re))
    else $error("entry RAM read and write in one cycle");

  // no RAM access without an accepted word
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_fire |-> !(mem_we || mem_re))
    else $error("entry RAM accessed without accepted word");

  // a good pop reads the RAM and shows RAM data next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && mem_re) |=> (out_valid_q && res_q.sel == mse_pkg::VAL_RAM))
    else $error("pop result not taken from RAM");

  // a dropped push carries a zero word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status == mse_pkg::ST_DROPPED) |-> res_q.sel == mse_pkg::VAL_ZERO)
    else $error("dropped push with nonzero word");

  // RAM data under a pending pop result must not move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && res_q.sel == mse_pkg::VAL_RAM) |=> $stable(rdata))
    else $error("pop data changed while stalled");

endmodule

/* tb/stack_result_checker.sv */
`timescale 1ns / 1ps

module stack_result_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [mse_pkg::OpW-1:0]          operation_i,
  input  logic [mse_pkg::IdxW-1:0]         stack_index_i,
  input  logic [mse_pkg::WordW-1:0]        push_value_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [mse_pkg::WordW-1:0]        pop_value_i,
  input  logic [mse_pkg::StatusW-1:0]      status_i,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mse_pkg::CfgAddrW-1:0]     paddr,
  input  logic [mse_pkg::CfgDataW-1:0]     pwdata,
  input  logic                             pready,
  output int unsigned                      fault_cnt_o,
  output int unsigned                      owed_o
);

  typedef struct packed {
    logic [mse_pkg::WordW-1:0] value;
    mse_pkg::status_e          status;
  } stack_result_t;

  // Shadow of the block: limits, fill counts and stack entries
  mse_pkg::limit_t           limit_q [mse_pkg::NumLimitRegs];
  int unsigned               fill_q  [mse_pkg::NumStacksDef];
  logic [mse_pkg::WordW-1:0] entry_q [mse_pkg::NumStacksDef][mse_pkg::MaxDepthDef];

  stack_result_t    owed_results_q [$];
  stack_result_t    want;
  int unsigned      fault_cnt = 0;
  int unsigned      owed      = 0;
  int unsigned      reg_idx;

  assign fault_cnt_o = fault_cnt;
  assign owed_o      = owed;

  function automatic stack_result_t apply_stack_op(logic [mse_pkg::OpW-1:0] op,
                                                   logic [mse_pkg::IdxW-1:0] idx,
                                                   logic [mse_pkg::WordW-1:0] word);
    stack_result_t res;
    int unsigned   lim;
    int unsigned   cnt;
    res.value  = '0;
    res.status = mse_pkg::ST_DONE;
    case (op)
      mse_pkg::OP_PUSH: begin
        lim = limit_q[idx];
        if (lim > mse_pkg::MaxDepthDef) lim = mse_pkg::MaxDepthDef;
        cnt = fill_q[idx];
        if (lim == 0 || cnt >= lim) begin
          res.status = mse_pkg::ST_DROPPED;
        end else begin
          entry_q[idx][cnt] = word;
          fill_q[idx]       = cnt + 1;
        end
      end
      mse_pkg::OP_POP: begin
        if (fill_q[idx] == 0) begin
          res.value  = '1;
          res.status = mse_pkg::ST_EMPTY;
        end else begin
          cnt         = fill_q[idx] - 1;
          res.value   = entry_q[idx][cnt];
          fill_q[idx] = cnt;
        end
      end
      mse_pkg::OP_CLEAR: fill_q[idx] = 0;
      default: ;
    endcase
    return res;
  endfunction

  task automatic note_fault(input string what);
    fault_cnt++;
    if (fault_cnt <= 10) $display("%0t: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (limit_q[i]) limit_q[i] = mse_pkg::LimitReset;
      foreach (fill_q[i]) fill_q[i] = 0;
      owed_results_q.delete();
      owed = 0;
    end else begin
      // result side first: its word always belongs to an earlier input word
      if (out_valid_i && out_ready_i) begin
        if (owed_results_q.size() == 0) begin
          note_fault($sformatf("unexpected result word value=%h status=%0d",
                               pop_value_i, status_i));
        end else begin
          want = owed_results_q.pop_front();
          if (pop_value_i !== want.value || status_i !== want.status)
            note_fault($sformatf("expected value=%h status=%0d, got value=%h status=%0d",
                                 want.value, want.status, pop_value_i, status_i));
        end
      end
      if (in_valid_i && in_ready_i)
        owed_results_q.insert(owed_results_q.size(),
                              apply_stack_op(operation_i, stack_index_i, push_value_i));
      if (psel && penable && pwrite && pready) begin
        reg_idx = paddr >> mse_pkg::RegSelLsb;
        if (reg_idx < mse_pkg::NumLimitRegs) limit_q[reg_idx] = pwdata[mse_pkg::LimitW-1:0];
      end
      owed = owed_results_q.size();
    end
  end

endmodule

/* tb/tb_multi_stack_engine_unit.sv */
`timescale 1ns / 1ps

module tb_multi_stack_engine_unit;

  // Operation code the block has no use for; must be a no-op
  localparam logic [mse_pkg::OpW-1:0] OpReserved = 2'd3;
  // Longest stretch without any accepted word before the run is declared hung
  localparam int unsigned    StallLimit = 4000;
  localparam int unsigned    NumPhases  = 11;
  localparam int unsigned    PhaseWords = 100;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [mse_pkg::OpW-1:0]          operation = '0;
  logic [mse_pkg::IdxW-1:0]         stack_index = '0;
  logic signed [mse_pkg::WordW-1:0] push_value = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [mse_pkg::WordW-1:0] pop_value;
  logic [mse_pkg::StatusW-1:0]      status;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [mse_pkg::CfgAddrW-1:0]     paddr = '0;
  logic [mse_pkg::CfgDataW-1:0]     pwdata = '0;
  logic [mse_pkg::CfgDataW-1:0]     prdata;
  logic                             pready;

  int unsigned fault_cnt;
  int unsigned results_owed;
  int unsigned stall_cycles = 0;
  // idling style per side: 0 none, 1 uniform random gap, 2 rare bursts
  int unsigned send_mode = 0;
  int unsigned recv_mode = 0;

  always #4 clk_i = ~clk_i;

  multi_stack_engine_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .operation_i   (operation),
    .stack_index_i (stack_index),
    .push_value_i  (push_value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .pop_value_o   (pop_value),
    .status_o      (status),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  stack_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .operation_i   (operation),
    .stack_index_i (stack_index),
    .push_value_i  (push_value),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .pop_value_i   (pop_value),
    .status_i      (status),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fault_cnt_o   (fault_cnt),
    .owed_o        (results_owed)
  );

  function automatic int unsigned draw_gap(int unsigned mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 18);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  // Words biased toward the sign and all-ones extremes and small values, else fully random
  function automatic logic [mse_pkg::WordW-1:0] draw_word();
    case ($urandom_range(0, 5))
      0:       return 64'h7FFF_FFFF_FFFF_FFFF;
      1:       return 64'h8000_0000_0000_0000;
      2:       return '1;
      3:       return mse_pkg::WordW'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic mse_pkg::limit_t draw_limit();
    case ($urandom_range(0, 5))
      0:       return mse_pkg::limit_t'(0);
      1:       return mse_pkg::limit_t'(1);
      2:       return mse_pkg::limit_t'(16);
      3:       return mse_pkg::limit_t'(31);
      4:       return mse_pkg::limit_t'($urandom_range(2, 15));
      default: return mse_pkg::limit_t'($urandom_range(17, 31));
    endcase
  endfunction

  // One input word: optional gap (valid low), then hold valid until taken.
  // Valid is left high after the accept so back-to-back words never toggle it.
  task automatic send_word(input logic [mse_pkg::OpW-1:0] op,
                           input logic [mse_pkg::IdxW-1:0] idx,
                           input logic [mse_pkg::WordW-1:0] word);
    int unsigned gap;
    gap = draw_gap(send_mode);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid    = 1'b1;
    operation   = op;
    stack_index = idx;
    push_value  = word;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Block goes idle: no input pending, every result back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (results_owed != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // APB write with setup and access phases; random upper bits check that only the low bits count
  task automatic write_limit(input int unsigned idx, input mse_pkg::limit_t lim);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = mse_pkg::CfgAddrW'(idx << mse_pkg::RegSelLsb);
    pwdata  = {(mse_pkg::CfgDataW-mse_pkg::LimitW)'($urandom), lim};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Hang detector: any accepted word on any port resets the count
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Result side: per word a random stall, then ready until the word is taken.
  // The stall style changes every few dozen words.
  initial begin : result_sink
    int unsigned gap;
    int unsigned left_in_mode;
    left_in_mode = 0;
    forever begin
      if (left_in_mode == 0) begin
        recv_mode    = $urandom_range(0, 2);
        left_in_mode = $urandom_range(20, 60);
      end
      left_in_mode--;
      gap = draw_gap(recv_mode);
      @(negedge clk_i);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready = 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  initial begin : stimulus
    int unsigned                bias;
    int unsigned                roll;
    int unsigned                phase;
    logic [mse_pkg::IdxW-1:0]   focus;
    logic [mse_pkg::OpW-1:0]    op;
    logic [mse_pkg::IdxW-1:0]   idx;
    mse_pkg::limit_t            lim;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // --- directed: reset limits (16) ---
    send_mode = 1;
    // extremes in and out in LIFO order, then pop past the bottom
    send_word(mse_pkg::OP_PUSH, 2'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_word(mse_pkg::OP_PUSH, 2'd0, 64'h8000_0000_0000_0000);
    send_word(mse_pkg::OP_PUSH, 2'd0, '1);
    send_word(mse_pkg::OP_POP, 2'd0, '0);
    send_word(mse_pkg::OP_POP, 2'd0, '0);
    send_word(mse_pkg::OP_POP, 2'd0, '0);
    send_word(mse_pkg::OP_POP, 2'd0, '1);
    // clear drops held entries
    send_word(mse_pkg::OP_PUSH, 2'd1, 64'h5555_5555_5555_5555);
    send_word(mse_pkg::OP_PUSH, 2'd1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(mse_pkg::OP_CLEAR, 2'd1, '0);
    send_word(mse_pkg::OP_POP, 2'd1, '0);
    // reserved code is a no-op
    send_word(OpReserved, 2'd2, '1);
    send_word(mse_pkg::OP_PUSH, 2'd3, 64'h0123_4567_89AB_CDEF);
    send_word(mse_pkg::OP_POP, 2'd3, '0);

    // --- directed: disabled, limit of one, limit above depth ---
    wait_drained();
    write_limit(0, mse_pkg::limit_t'(0));
    write_limit(1, mse_pkg::limit_t'(1));
    write_limit(2, mse_pkg::limit_t'(31));
    write_limit(3, mse_pkg::limit_t'(16));
    send_word(mse_pkg::OP_PUSH, 2'd0, 64'h1);
    send_word(mse_pkg::OP_POP, 2'd0, '0);
    send_word(mse_pkg::OP_PUSH, 2'd1, 64'h2);
    send_word(mse_pkg::OP_PUSH, 2'd1, 64'h3);
    send_word(mse_pkg::OP_POP, 2'd1, '0);
    send_word(mse_pkg::OP_CLEAR, 2'd2, '0);
    send_word(mse_pkg::OP_PUSH, 2'd3, 64'hDEAD_BEEF_0000_0001);
    send_word(mse_pkg::OP_PUSH, 2'd3, 64'hDEAD_BEEF_0000_0002);
    send_word(mse_pkg::OP_PUSH, 2'd3, 64'hDEAD_BEEF_0000_0003);

    // limit lowered under the fill count: push blocked, pops still drain
    wait_drained();
    write_limit(3, mse_pkg::limit_t'(1));
    send_word(mse_pkg::OP_PUSH, 2'd3, 64'h4);
    send_word(mse_pkg::OP_POP, 2'd3, '0);
    // stack disabled while holding entries: pops still work
    wait_drained();
    write_limit(3, mse_pkg::limit_t'(0));
    send_word(mse_pkg::OP_POP, 2'd3, '0);

    // --- random phases: new limits, then a mix weighted per phase ---
    for (phase = 0; phase < NumPhases; phase++) begin
      wait_drained();
      for (int unsigned r = 0; r < mse_pkg::NumLimitRegs; r++) begin
        case (phase)
          0:       lim = mse_pkg::limit_t'(31);
          1:       lim = mse_pkg::limit_t'(16);
          2:       lim = (r == 0) ? mse_pkg::limit_t'(0) : mse_pkg::limit_t'(1);
          default: lim = draw_limit();
        endcase
        write_limit(r, lim);
      end
      send_mode = (phase == 1) ? 0 : $urandom_range(0, 2);
      // heavy push phases fill a stack to its limit, light ones drain it
      bias  = $urandom_range(35, 70);
      focus = mse_pkg::IdxW'($urandom_range(0, 3));
      repeat (PhaseWords) begin
        roll = $urandom_range(0, 99);
        if (roll < bias)     op = mse_pkg::OP_PUSH;
        else if (roll < 92)  op = mse_pkg::OP_POP;
        else if (roll < 96)  op = mse_pkg::OP_CLEAR;
        else                 op = OpReserved;
        idx = ($urandom_range(0, 3) == 0) ? mse_pkg::IdxW'($urandom_range(0, 3)) : focus;
        send_word(op, idx, draw_word());
        if ($urandom_range(0, 39) == 0) focus = mse_pkg::IdxW'($urandom_range(0, 3));
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (fault_cnt == 0 && results_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
